// ===== rtl/swmm_pkg.sv =====
package swmm_pkg;

   localparam int POS_BITS   = 20;
   localparam int TOTAL_BITS = 40;
   localparam int CFG_BITS   = 7;
   localparam int FIFO_DEPTH = 2;

   localparam logic [CFG_BITS-1:0] CFG_RESET = CFG_BITS'(4);

   localparam logic signed [TOTAL_BITS-1:0] TOTAL_MAX = {1'b0, {(TOTAL_BITS-1){1'b1}}};
   localparam logic signed [TOTAL_BITS-1:0] TOTAL_MIN = {1'b1, {(TOTAL_BITS-1){1'b0}}};

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_WORK,
      ST_FIN
   } state_type;

   // classification the front end attaches to each word
   typedef struct packed {
      logic                last;
      logic                full;
      logic [CFG_BITS-1:0] k;
      logic [POS_BITS-1:0] pos;
   } ctl_type;

   typedef struct packed {
      logic active;
      logic push;
      logic clear;
   } mono_cmd_type;

endpackage

// ===== rtl/swmm_if.sv =====
interface swmm_req_if #(parameter int SAMPLE_BITS = 16);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample;
   logic                          last_of_sequence;

   modport source (output valid, sample, last_of_sequence, input ready);
   modport sink   (input valid, sample, last_of_sequence, output ready);
endinterface

interface swmm_rsp_if import swmm_pkg::*; #(parameter int SAMPLE_BITS = 16);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] window_max;
   logic signed [SAMPLE_BITS-1:0] window_min;
   logic signed [TOTAL_BITS-1:0]  running_total;
   logic                          is_final;
   logic                          short_sequence;

   modport source (output valid, window_max, window_min, running_total, is_final,
                   short_sequence, input ready);
   modport sink   (input valid, window_max, window_min, running_total, is_final,
                   short_sequence, output ready);
endinterface

interface swmm_csr_if import swmm_pkg::*;;
   logic                valid;
   logic                ready;
   logic [CFG_BITS-1:0] window_size;

   modport source (output valid, window_size, input ready);
   modport sink   (input valid, window_size, output ready);
endinterface

// ===== rtl/swmm_front.sv =====
module swmm_front import swmm_pkg::*; #(
   parameter int WINDOW_MAX  = 64,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   swmm_req_if.sink                      req_bus,
   swmm_csr_if.sink                      csr_bus,
   output logic                          push_valid,
   input  logic                          push_ready,
   output ctl_type                       push_ctl,
   output logic signed [SAMPLE_BITS-1:0] push_sample
);

   logic [CFG_BITS-1:0] window_size_ff, window_size_in;
   logic [POS_BITS-1:0] pos_ff, pos_in;
   logic                wrapped_ff, wrapped_in;
   logic [CFG_BITS-1:0] k_eff;
   logic [POS_BITS:0]   pos_next;
   logic                full;
   logic                accept;

   always_comb begin
      k_eff = window_size_ff;
      if (window_size_ff == '0) begin
         k_eff = CFG_BITS'(1);
      end else if (int'(window_size_ff) > WINDOW_MAX) begin
         k_eff = CFG_BITS'(WINDOW_MAX);
      end
      pos_next = (POS_BITS+1)'(pos_ff) + (POS_BITS+1)'(1);
      full     = wrapped_ff || (pos_next >= (POS_BITS+1)'(k_eff));
   end

   assign accept        = req_bus.valid && push_ready;
   assign req_bus.ready = push_ready;
   assign push_valid    = req_bus.valid;
   assign push_sample   = req_bus.sample;
   assign push_ctl      = '{last: req_bus.last_of_sequence, full: full, k: k_eff, pos: pos_ff};
   assign csr_bus.ready = 1'b1;

   always_comb begin
      window_size_in = window_size_ff;
      pos_in         = pos_ff;
      wrapped_in     = wrapped_ff;
      if (csr_bus.valid) begin
         window_size_in = csr_bus.window_size;
      end
      if (accept) begin
         if (req_bus.last_of_sequence) begin
            // sequence ends: restart numbering
            pos_in     = '0;
            wrapped_in = 1'b0;
         end else begin
            pos_in     = pos_next[POS_BITS-1:0];
            wrapped_in = wrapped_ff | pos_next[POS_BITS];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_size_ff <= CFG_RESET;
         pos_ff         <= '0;
         wrapped_ff     <= 1'b0;
      end else begin
         window_size_ff <= window_size_in;
         pos_ff         <= pos_in;
         wrapped_ff     <= wrapped_in;
      end
   end

endmodule

// ===== rtl/swmm_fifo.sv =====
module swmm_fifo import swmm_pkg::*; #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [WIDTH-1:0] in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [WIDTH-1:0] out_data
);

   localparam int AW = $clog2(FIFO_DEPTH);
   localparam int LW = $clog2(FIFO_DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [FIFO_DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [LW-1:0]    level_ff, level_in;
   logic             do_push;
   logic             do_pop;

   assign in_ready  = (level_ff != LW'(FIFO_DEPTH));
   assign out_valid = (level_ff != '0);
   assign out_data  = slot_ff[rd_ptr_ff];
   assign do_push   = in_valid && in_ready;
   assign do_pop    = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      level_in  = level_ff;
      if (do_push) begin
         wr_ptr_in = wr_ptr_ff + AW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = rd_ptr_ff + AW'(1);
      end
      if (do_push && !do_pop) begin
         level_in = level_ff + LW'(1);
      end else if (do_pop && !do_push) begin
         level_in = level_ff - LW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule

// ===== rtl/swmm_mono.sv =====
module swmm_mono import swmm_pkg::*; #(
   parameter int WINDOW_MAX  = 64,
   parameter int SAMPLE_BITS = 16,
   parameter bit KEEP_MAX    = 1'b1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  mono_cmd_type                  cmd,
   input  logic signed [SAMPLE_BITS-1:0] sample,
   input  logic [POS_BITS-1:0]           pos,
   input  logic [CFG_BITS-1:0]           k,
   output logic                          done,
   output logic signed [SAMPLE_BITS-1:0] front_value
);

   localparam int AW = $clog2(WINDOW_MAX);
   localparam int CW = $clog2(WINDOW_MAX + 1);
   localparam int EW = SAMPLE_BITS + POS_BITS;

   logic [EW-1:0] mem [WINDOW_MAX];
   logic [EW-1:0] rd_head_ff;
   logic [EW-1:0] rd_back_ff;
   logic [AW-1:0] head_ff, head_in;
   logic [CW-1:0] count_ff, count_in;
   logic [AW-1:0] tail_addr;
   logic [AW-1:0] back_addr_in;
   logic [POS_BITS-1:0] age;
   logic signed [SAMPLE_BITS-1:0] head_val;
   logic signed [SAMPLE_BITS-1:0] back_val;
   logic          back_hit;
   logic          evict_need;
   logic          pop_need;
   logic          we;

   function automatic logic [AW-1:0] wrap_idx(input logic [AW:0] s);
      logic [AW:0] r;
      r = (s >= (AW+1)'(WINDOW_MAX)) ? s - (AW+1)'(WINDOW_MAX) : s;
      return r[AW-1:0];
   endfunction

   assign head_val = rd_head_ff[EW-1:POS_BITS];
   assign back_val = rd_back_ff[EW-1:POS_BITS];
   assign age      = pos - rd_head_ff[POS_BITS-1:0];

   always_comb begin
      if (KEEP_MAX) begin
         back_hit = (back_val <= sample);
      end else begin
         back_hit = (back_val >= sample);
      end
      evict_need = (count_ff != '0) && (age >= POS_BITS'(k));
      pop_need   = !evict_need && (count_ff != '0) && back_hit;
      done       = !evict_need && !pop_need;
      // an emptied queue takes the new word as its front
      front_value = (count_ff == '0) ? sample : head_val;
      tail_addr   = wrap_idx((AW+1)'(head_ff) + (AW+1)'(count_ff));
      we          = cmd.active && cmd.push && done;
   end

   always_comb begin
      head_in  = head_ff;
      count_in = count_ff;
      if (cmd.clear) begin
         head_in  = '0;
         count_in = '0;
      end else if (cmd.active) begin
         if (evict_need) begin
            // drop the front entry that aged out of the window
            head_in  = wrap_idx((AW+1)'(head_ff) + (AW+1)'(1));
            count_in = count_ff - CW'(1);
         end else if (pop_need) begin
            count_in = count_ff - CW'(1);
         end else if (cmd.push) begin
            count_in = count_ff + CW'(1);
         end
      end
      if (count_in == '0) begin
         back_addr_in = head_in;
      end else begin
         back_addr_in = wrap_idx((AW+1)'(head_in) + (AW+1)'(count_in) - (AW+1)'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   // read ports follow the next head and back so the data matches the registers
   always_ff @(posedge clock) begin
      if (we) begin
         mem[tail_addr] <= {sample, pos};
      end
      rd_head_ff <= mem[head_in];
      rd_back_ff <= mem[back_addr_in];
   end

endmodule

// ===== rtl/swmm_back.sv =====
module swmm_back import swmm_pkg::*; #(
   parameter int WINDOW_MAX  = 64,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          item_valid,
   output logic                          item_ready,
   input  ctl_type                       item_ctl,
   input  logic signed [SAMPLE_BITS-1:0] item_sample,
   swmm_rsp_if.source                    rsp_bus,
   output state_type                     back_state
);

   state_type                     state_ff, state_in;
   ctl_type                       ctl_ff, ctl_in;
   logic signed [SAMPLE_BITS-1:0] sample_ff, sample_in;
   logic signed [SAMPLE_BITS-1:0] mx_ff, mx_in;
   logic signed [SAMPLE_BITS-1:0] mn_ff, mn_in;
   logic signed [SAMPLE_BITS:0]   pair_ff, pair_in;
   logic signed [TOTAL_BITS-1:0]  total_ff, total_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_BITS-1:0] rsp_max_ff, rsp_max_in;
   logic signed [SAMPLE_BITS-1:0] rsp_min_ff, rsp_min_in;
   logic signed [TOTAL_BITS-1:0]  rsp_total_ff, rsp_total_in;
   logic                          rsp_final_ff, rsp_final_in;
   logic                          rsp_short_ff, rsp_short_in;

   mono_cmd_type                  cmd;
   logic                          max_done;
   logic                          min_done;
   logic signed [SAMPLE_BITS-1:0] max_front;
   logic signed [SAMPLE_BITS-1:0] min_front;
   logic signed [TOTAL_BITS:0]    sum;
   logic signed [TOTAL_BITS-1:0]  sat;
   logic                          out_free;
   logic                          needs_result;
   logic                          fin_go;

   swmm_mono #(
      .WINDOW_MAX  (WINDOW_MAX),
      .SAMPLE_BITS (SAMPLE_BITS),
      .KEEP_MAX    (1'b1)
   ) u_max_q (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sample      (sample_ff),
      .pos         (ctl_ff.pos),
      .k           (ctl_ff.k),
      .done        (max_done),
      .front_value (max_front)
   );

   swmm_mono #(
      .WINDOW_MAX  (WINDOW_MAX),
      .SAMPLE_BITS (SAMPLE_BITS),
      .KEEP_MAX    (1'b0)
   ) u_min_q (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sample      (sample_ff),
      .pos         (ctl_ff.pos),
      .k           (ctl_ff.k),
      .done        (min_done),
      .front_value (min_front)
   );

   assign out_free     = !rsp_valid_ff || rsp_bus.ready;
   assign needs_result = ctl_ff.full || ctl_ff.last;
   assign fin_go       = (state_ff == ST_FIN) && (out_free || !needs_result);

   always_comb begin
      sum = (TOTAL_BITS+1)'(total_ff) + (TOTAL_BITS+1)'(pair_ff);
      if (sum[TOTAL_BITS] != sum[TOTAL_BITS-1]) begin
         sat = sum[TOTAL_BITS] ? TOTAL_MIN : TOTAL_MAX;
      end else begin
         sat = sum[TOTAL_BITS-1:0];
      end
   end

   always_comb begin
      cmd.active = (state_ff == ST_WORK);
      cmd.push   = (state_ff == ST_WORK) && max_done && min_done;
      cmd.clear  = fin_go && ctl_ff.last;
   end

   always_comb begin
      state_in     = state_ff;
      ctl_in       = ctl_ff;
      sample_in    = sample_ff;
      mx_in        = mx_ff;
      mn_in        = mn_ff;
      pair_in      = pair_ff;
      total_in     = total_ff;
      item_ready   = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_max_in   = rsp_max_ff;
      rsp_min_in   = rsp_min_ff;
      rsp_total_in = rsp_total_ff;
      rsp_final_in = rsp_final_ff;
      rsp_short_in = rsp_short_ff;
      case (state_ff)
         ST_LOAD: begin
            item_ready = 1'b1;
            if (item_valid) begin
               ctl_in    = item_ctl;
               sample_in = item_sample;
               state_in  = ST_WORK;
            end
         end
         ST_WORK: begin
            if (cmd.push) begin
               mx_in    = max_front;
               mn_in    = min_front;
               pair_in  = (SAMPLE_BITS+1)'(max_front) + (SAMPLE_BITS+1)'(min_front);
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (fin_go) begin
               if (ctl_ff.full) begin
                  rsp_valid_in = 1'b1;
                  rsp_max_in   = mx_ff;
                  rsp_min_in   = mn_ff;
                  rsp_total_in = sat;
                  rsp_final_in = ctl_ff.last;
                  rsp_short_in = 1'b0;
                  total_in     = sat;
               end else if (ctl_ff.last) begin
                  // sequence ended before any window filled
                  rsp_valid_in = 1'b1;
                  rsp_max_in   = '0;
                  rsp_min_in   = '0;
                  rsp_total_in = '0;
                  rsp_final_in = 1'b1;
                  rsp_short_in = 1'b1;
               end
               if (ctl_ff.last) begin
                  total_in = '0;
               end
               item_ready = 1'b1;
               if (item_valid) begin
                  ctl_in    = item_ctl;
                  sample_in = item_sample;
                  state_in  = ST_WORK;
               end else begin
                  state_in = ST_LOAD;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ctl_ff       <= ctl_in;
      sample_ff    <= sample_in;
      mx_ff        <= mx_in;
      mn_ff        <= mn_in;
      pair_ff      <= pair_in;
      rsp_max_ff   <= rsp_max_in;
      rsp_min_ff   <= rsp_min_in;
      rsp_total_ff <= rsp_total_in;
      rsp_final_ff <= rsp_final_in;
      rsp_short_ff <= rsp_short_in;
   end

   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.window_max     = rsp_max_ff;
   assign rsp_bus.window_min     = rsp_min_ff;
   assign rsp_bus.running_total  = rsp_total_ff;
   assign rsp_bus.is_final       = rsp_final_ff;
   assign rsp_bus.short_sequence = rsp_short_ff;
   assign back_state             = state_ff;

endmodule

// ===== rtl/sliding_window_min_max_sum_core.sv =====
// channel  dir  handshake    word
// req_bus  in   valid/ready  sample, last_of_sequence
// rsp_bus  out  valid/ready  window_max, window_min, running_total, is_final, short_sequence
// csr_bus  in   valid/ready  window_size (ready always high)
//
// A sample works in the back end through S steps, S being the larger of the two queues'
// count of front evictions plus back pops for that sample, then a push and a finish step;
// each queue memory does one evict or pop step per cycle. A two-word queue decouples the
// front end, so input is taken while the back end or a waiting result is stalled, until
// that queue is full. Reset is synchronous and clears control state only; queue memories need no clearing pass.
module sliding_window_min_max_sum_core import swmm_pkg::*; #(
   parameter int WINDOW_MAX  = 64,
   parameter int SAMPLE_BITS = 16
) (
   input  logic       clock,
   input  logic       reset,
   swmm_req_if.sink   req_bus,
   swmm_rsp_if.source rsp_bus,
   swmm_csr_if.sink   csr_bus
);

   localparam int ITEM_BITS = $bits(ctl_type) + SAMPLE_BITS;

   logic                          f_in_valid;
   logic                          f_in_ready;
   ctl_type                       f_in_ctl;
   logic signed [SAMPLE_BITS-1:0] f_in_sample;
   logic [ITEM_BITS-1:0]          f_in_data;
   logic                          f_out_valid;
   logic                          f_out_ready;
   logic [ITEM_BITS-1:0]          f_out_data;
   ctl_type                       f_out_ctl;
   logic signed [SAMPLE_BITS-1:0] f_out_sample;
   state_type                     back_state;

   swmm_front #(
      .WINDOW_MAX  (WINDOW_MAX),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .csr_bus     (csr_bus),
      .push_valid  (f_in_valid),
      .push_ready  (f_in_ready),
      .push_ctl    (f_in_ctl),
      .push_sample (f_in_sample)
   );

   assign f_in_data = {f_in_ctl, f_in_sample};

   swmm_fifo #(
      .WIDTH (ITEM_BITS)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_in_valid),
      .in_ready  (f_in_ready),
      .in_data   (f_in_data),
      .out_valid (f_out_valid),
      .out_ready (f_out_ready),
      .out_data  (f_out_data)
   );

   assign f_out_ctl    = f_out_data[ITEM_BITS-1:SAMPLE_BITS];
   assign f_out_sample = f_out_data[SAMPLE_BITS-1:0];

   swmm_back #(
      .WINDOW_MAX  (WINDOW_MAX),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .item_valid  (f_out_valid),
      .item_ready  (f_out_ready),
      .item_ctl    (f_out_ctl),
      .item_sample (f_out_sample),
      .rsp_bus     (rsp_bus),
      .back_state  (back_state)
   );

   a_short_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.short_sequence |->
         rsp_bus.is_final && rsp_bus.running_total == '0 &&
         rsp_bus.window_max == '0 && rsp_bus.window_min == '0)
      else $error("short result carries nonzero fields or no final flag");

   a_rsp_from_fin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_bus.valid) |-> $past(back_state) == ST_FIN)
      else $error("result raised outside the finish step");

   a_pop_state: assert property (@(posedge clock) disable iff (reset)
      f_out_valid && f_out_ready |-> back_state == ST_LOAD || back_state == ST_FIN)
      else $error("word taken from queue while back end busy");

endmodule
